// ===== rtl/lprd_pkg.sv =====
// lprd_pkg: shared widths, codes and types of the length-prefixed request deframer
// no dependencies; used by the channel interfaces and the deframer core

package lprd_pkg;

   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned KIND_WIDTH      = 3;
   localparam int unsigned INDEX_WIDTH     = 16;
   localparam int unsigned CODE_WIDTH      = 3;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned WORD_WIDTH      = 32;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_MESSAGE_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ARGUMENT_COUNT = 1'b1;

   localparam logic [CSR_DATA_WIDTH-1:0] MAX_MESSAGE_LENGTH_RESET = 16'd4096;
   localparam logic [CSR_DATA_WIDTH-1:0] MAX_ARGUMENT_COUNT_RESET = 16'd1024;

   // length words below this size cannot hold an argument-count word
   localparam logic [WORD_WIDTH-1:0] MIN_BODY_LENGTH = 32'd4;
   localparam logic [INDEX_WIDTH-1:0] HEADER_BYTES   = 16'd4;

   // byte kinds
   localparam logic [KIND_WIDTH-1:0] KIND_MESSAGE_LENGTH  = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ARGUMENT_COUNT  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_ARGUMENT_LENGTH = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_ARGUMENT_DATA   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_DISCARDED       = 3'd4;

   // framing error codes
   localparam logic [CODE_WIDTH-1:0] ERR_NONE            = 3'd0;
   localparam logic [CODE_WIDTH-1:0] ERR_TOO_LONG        = 3'd1;
   localparam logic [CODE_WIDTH-1:0] ERR_BODY_SHORT      = 3'd2;
   localparam logic [CODE_WIDTH-1:0] ERR_TOO_MANY_ARGS   = 3'd3;
   localparam logic [CODE_WIDTH-1:0] ERR_HEADER_OVERRUN  = 3'd4;
   localparam logic [CODE_WIDTH-1:0] ERR_PAYLOAD_OVERRUN = 3'd5;
   localparam logic [CODE_WIDTH-1:0] ERR_TRAILING        = 3'd6;

   typedef enum logic [4:0] {
      PH_LENGTH  = 5'b00001,
      PH_COUNT   = 5'b00010,
      PH_ARGLEN  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_ERROR   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  byte_kind;
      logic [BYTE_WIDTH-1:0]  payload_byte;
      logic [INDEX_WIDTH-1:0] argument_index;
      logic                   argument_end;
      logic                   message_end;
      logic [INDEX_WIDTH-1:0] argument_total;
      logic                   error_flag;
      logic [CODE_WIDTH-1:0]  error_code;
   } rsp_type;

endpackage

// ===== rtl/lprd_req_if.sv =====
// lprd_req_if: request byte channel, valid/ready with one data byte per item
// depends on lprd_pkg for the byte width

interface lprd_req_if;
   logic                             valid;
   logic                             ready;
   logic [lprd_pkg::BYTE_WIDTH-1:0]  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/lprd_rsp_if.sv =====
// lprd_rsp_if: tagged byte result channel, valid/ready with the deframer result fields
// depends on lprd_pkg for the field widths

interface lprd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lprd_pkg::KIND_WIDTH-1:0]   byte_kind;
   logic [lprd_pkg::BYTE_WIDTH-1:0]   payload_byte;
   logic [lprd_pkg::INDEX_WIDTH-1:0]  argument_index;
   logic                              argument_end;
   logic                              message_end;
   logic [lprd_pkg::INDEX_WIDTH-1:0]  argument_total;
   logic                              error_flag;
   logic [lprd_pkg::CODE_WIDTH-1:0]   error_code;

   modport source (output valid, output byte_kind, output payload_byte,
                   output argument_index, output argument_end, output message_end,
                   output argument_total, output error_flag, output error_code,
                   input ready);
   modport sink (input valid, input byte_kind, input payload_byte,
                 input argument_index, input argument_end, input message_end,
                 input argument_total, input error_flag, input error_code,
                 output ready);
endinterface

// ===== rtl/length_prefixed_request_deframer_core.sv =====
// length_prefixed_request_deframer_core: tags a length-prefixed request byte stream
// depends on lprd_pkg, lprd_req_if and lprd_rsp_if
//
// the deframer takes one request byte per cycle while rsp is ready and returns
// one tagged result item per byte, sustaining one item every clock cycle with no
// bubbles. each byte goes through an input register, then the framing logic
// (field assembly, length and count checks, body and argument down-counters)
// updates the parser state and loads the result register. the input register
// takes a new item whenever the result register is empty or being drained, so
// back-pressure on rsp reaches req in the same cycle. length words are
// little-endian 32-bit; the message body holds an argument-count word and then
// length-prefixed argument strings. the first framing error is flagged on the
// byte that decides it, after which every byte comes out as discarded until
// reset. the two limits on the csr port may be written only while the block is
// idle.

module length_prefixed_request_deframer_core (
   input  logic                                    clock,
   input  logic                                    reset,
   lprd_req_if.sink                                req,
   lprd_rsp_if.source                              rsp,
   input  logic                                    csr_write_enable,
   input  logic [lprd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [lprd_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   localparam int unsigned IW = lprd_pkg::INDEX_WIDTH;

   // result of the end-of-argument decision
   typedef struct packed {
      logic [lprd_pkg::CODE_WIDTH-1:0] code;
      logic                            done;
      logic                            to_arglen;
   } next_step_type;

   // limits
   logic [lprd_pkg::CSR_DATA_WIDTH-1:0] max_len_ff;
   logic [lprd_pkg::CSR_DATA_WIDTH-1:0] max_args_ff;

   // input register
   logic                              in_valid_ff;
   logic [lprd_pkg::BYTE_WIDTH-1:0]   in_byte_ff;

   // parser state
   lprd_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]           field_cnt_ff, field_cnt_in;
   logic [23:0]          field_acc_ff, field_acc_in;   // low three bytes of the field
   logic [IW-1:0]        body_left_ff, body_left_in;
   logic [IW-1:0]        args_left_ff, args_left_in;
   logic [IW-1:0]        cur_arg_ff, cur_arg_in;
   logic [IW-1:0]        arg_left_ff, arg_left_in;
   logic [IW-1:0]        msg_args_ff, msg_args_in;

   // result register
   logic                 out_valid_ff;
   lprd_pkg::rsp_type    out_ff, out_in;

   logic                 advance;

   // after the count word or an argument: end of message, next header or an error
   function automatic next_step_type after_argument(input logic [IW-1:0] args_left,
                                                    input logic [IW-1:0] body_left);
      next_step_type s;
      s = '{code: lprd_pkg::ERR_NONE, done: 1'b0, to_arglen: 1'b0};
      if (args_left == '0) begin
         if (body_left == '0) begin
            s.done = 1'b1;
         end else begin
            s.code = lprd_pkg::ERR_TRAILING;
         end
      end else if (body_left < lprd_pkg::HEADER_BYTES) begin
         s.code = lprd_pkg::ERR_HEADER_OVERRUN;
      end else begin
         s.to_arglen = 1'b1;
      end
      return s;
   endfunction

   // the input register moves on when the result slot is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= lprd_pkg::MAX_MESSAGE_LENGTH_RESET;
         max_args_ff <= lprd_pkg::MAX_ARGUMENT_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lprd_pkg::CSR_MAX_MESSAGE_LENGTH: max_len_ff  <= csr_write_data;
            lprd_pkg::CSR_MAX_ARGUMENT_COUNT: max_args_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.data_byte;
      end
   end

   // framing logic for the byte in the input register
   always_comb begin
      logic [lprd_pkg::WORD_WIDTH-1:0] word;
      logic                            complete;
      logic [IW-1:0]                   body_dec;
      logic [IW-1:0]                   arg_dec;
      logic [IW-1:0]                   args_dec;
      next_step_type                   step;

      phase_in     = phase_ff;
      field_cnt_in = field_cnt_ff;
      field_acc_in = field_acc_ff;
      body_left_in = body_left_ff;
      args_left_in = args_left_ff;
      cur_arg_in   = cur_arg_ff;
      arg_left_in  = arg_left_ff;
      msg_args_in  = msg_args_ff;

      word     = {in_byte_ff, field_acc_ff};
      complete = (field_cnt_ff == 2'd3);
      body_dec = body_left_ff - IW'(1);
      arg_dec  = arg_left_ff - IW'(1);
      args_dec = args_left_ff - IW'(1);
      step     = '{code: lprd_pkg::ERR_NONE, done: 1'b0, to_arglen: 1'b0};

      out_in                = '0;
      out_in.payload_byte   = in_byte_ff;

      // assemble header fields little-endian
      if (phase_ff == lprd_pkg::PH_LENGTH || phase_ff == lprd_pkg::PH_COUNT ||
          phase_ff == lprd_pkg::PH_ARGLEN) begin
         field_cnt_in = field_cnt_ff + 2'd1;
         case (field_cnt_ff)
            2'd0:    field_acc_in = {field_acc_ff[23:8], in_byte_ff};
            2'd1:    field_acc_in = {field_acc_ff[23:16], in_byte_ff, field_acc_ff[7:0]};
            2'd2:    field_acc_in = {in_byte_ff, field_acc_ff[15:0]};
            default: field_acc_in = '0;
         endcase
      end

      unique case (phase_ff)
         lprd_pkg::PH_LENGTH: begin
            out_in.byte_kind = lprd_pkg::KIND_MESSAGE_LENGTH;
            if (complete) begin
               if (word > {16'd0, max_len_ff}) begin
                  step.code = lprd_pkg::ERR_TOO_LONG;
               end else if (word < lprd_pkg::MIN_BODY_LENGTH) begin
                  step.code = lprd_pkg::ERR_BODY_SHORT;
               end else begin
                  body_left_in = word[IW-1:0];
                  phase_in     = lprd_pkg::PH_COUNT;
               end
            end
         end
         lprd_pkg::PH_COUNT: begin
            out_in.byte_kind = lprd_pkg::KIND_ARGUMENT_COUNT;
            body_left_in     = body_dec;
            if (complete) begin
               if (word > {16'd0, max_args_ff}) begin
                  step.code = lprd_pkg::ERR_TOO_MANY_ARGS;
               end else begin
                  args_left_in = word[IW-1:0];
                  msg_args_in  = word[IW-1:0];
                  cur_arg_in   = '0;
                  step         = after_argument(word[IW-1:0], body_dec);
               end
            end
         end
         lprd_pkg::PH_ARGLEN: begin
            out_in.byte_kind      = lprd_pkg::KIND_ARGUMENT_LENGTH;
            out_in.argument_index = cur_arg_ff;
            body_left_in          = body_dec;
            if (complete) begin
               if (word > {16'd0, body_dec}) begin
                  step.code = lprd_pkg::ERR_PAYLOAD_OVERRUN;
               end else if (word == '0) begin
                  // zero-length argument ends on its header
                  out_in.argument_end = 1'b1;
                  args_left_in        = args_dec;
                  cur_arg_in          = cur_arg_ff + IW'(1);
                  step                = after_argument(args_dec, body_dec);
               end else begin
                  arg_left_in = word[IW-1:0];
                  phase_in    = lprd_pkg::PH_PAYLOAD;
               end
            end
         end
         lprd_pkg::PH_PAYLOAD: begin
            out_in.byte_kind      = lprd_pkg::KIND_ARGUMENT_DATA;
            out_in.argument_index = cur_arg_ff;
            body_left_in          = body_dec;
            arg_left_in           = arg_dec;
            if (arg_dec == '0) begin
               out_in.argument_end = 1'b1;
               args_left_in        = args_dec;
               cur_arg_in          = cur_arg_ff + IW'(1);
               step                = after_argument(args_dec, body_dec);
            end
         end
         lprd_pkg::PH_ERROR: begin
            out_in.byte_kind = lprd_pkg::KIND_DISCARDED;
         end
         default: begin
            out_in.byte_kind = lprd_pkg::KIND_DISCARDED;
         end
      endcase

      if (step.to_arglen) begin
         phase_in = lprd_pkg::PH_ARGLEN;
      end
      if (step.done) begin
         phase_in = lprd_pkg::PH_LENGTH;
      end

      // total reflects the count as it stands after this byte
      if (phase_ff != lprd_pkg::PH_ERROR) begin
         out_in.argument_total = msg_args_in;
      end

      if (step.code != lprd_pkg::ERR_NONE) begin
         phase_in            = lprd_pkg::PH_ERROR;
         out_in.argument_end = 1'b0;
         out_in.error_flag   = 1'b1;
         out_in.error_code   = step.code;
      end else if (step.done) begin
         out_in.message_end = 1'b1;
         msg_args_in        = '0;
         cur_arg_in         = '0;
         args_left_in       = '0;
         body_left_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lprd_pkg::PH_LENGTH;
         field_cnt_ff <= '0;
         field_acc_ff <= '0;
         body_left_ff <= '0;
         args_left_ff <= '0;
         cur_arg_ff   <= '0;
         arg_left_ff  <= '0;
         msg_args_ff  <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         field_cnt_ff <= field_cnt_in;
         field_acc_ff <= field_acc_in;
         body_left_ff <= body_left_in;
         args_left_ff <= args_left_in;
         cur_arg_ff   <= cur_arg_in;
         arg_left_ff  <= arg_left_in;
         msg_args_ff  <= msg_args_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.byte_kind      = out_ff.byte_kind;
   assign rsp.payload_byte   = out_ff.payload_byte;
   assign rsp.argument_index = out_ff.argument_index;
   assign rsp.argument_end   = out_ff.argument_end;
   assign rsp.message_end    = out_ff.message_end;
   assign rsp.argument_total = out_ff.argument_total;
   assign rsp.error_flag     = out_ff.error_flag;
   assign rsp.error_code     = out_ff.error_code;

   // once in error, the parser never leaves it
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lprd_pkg::PH_ERROR |=> phase_ff == lprd_pkg::PH_ERROR)
      else $error("deframer left the error phase");

   // an error item carries a code and never ends an argument or a message
   a_error_item: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.error_flag |->
         out_ff.error_code != lprd_pkg::ERR_NONE && !out_ff.argument_end &&
         !out_ff.message_end)
      else $error("error item with bad markers");

   // discarded items carry nothing but the byte
   a_discard_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.byte_kind == lprd_pkg::KIND_DISCARDED |->
         out_ff.argument_index == '0 && out_ff.argument_total == '0 &&
         !out_ff.error_flag && !out_ff.argument_end && !out_ff.message_end)
      else $error("discarded item with nonzero fields");

   // payload bytes are only taken on a field boundary
   a_payload_aligned: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lprd_pkg::PH_PAYLOAD |-> field_cnt_ff == 2'd0)
      else $error("payload phase inside a header field");

   // a held result is not overwritten
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result changed");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for length_prefixed_request_deframer_core; streams framed requests
// under random gaps and stalls and checks every tagged item against an in-bench deframer model
// depends on lprd_pkg, lprd_req_if, lprd_rsp_if and the deframer core

module tb;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_write_enable;
   logic [lprd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [lprd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   lprd_req_if req_if ();
   lprd_rsp_if rsp_if ();

   length_prefixed_request_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // deframer model: limits and parser state
   logic [lprd_pkg::CSR_DATA_WIDTH-1:0] limit_length;
   logic [lprd_pkg::CSR_DATA_WIDTH-1:0] limit_args;
   lprd_pkg::phase_type                 parse_phase;
   logic [1:0]                          field_bytes;
   logic [lprd_pkg::WORD_WIDTH-1:0]     field_word;
   logic [lprd_pkg::INDEX_WIDTH-1:0]    body_left;
   logic [lprd_pkg::INDEX_WIDTH-1:0]    args_left;
   logic [lprd_pkg::INDEX_WIDTH-1:0]    arg_index;
   logic [lprd_pkg::INDEX_WIDTH-1:0]    arg_bytes_left;
   logic [lprd_pkg::INDEX_WIDTH-1:0]    msg_arg_count;

   lprd_pkg::rsp_type                   tagged_q [$];
   logic [lprd_pkg::BYTE_WIDTH-1:0]     stream_q [$];
   int                                  error_count;
   bit                                  req_calm;
   bit                                  rsp_calm;
   int                                  rsp_stall;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #100_000_000;
      $display("tb: done, errors");
      $finish;
   end

   function automatic void model_reset();
      limit_length   = lprd_pkg::MAX_MESSAGE_LENGTH_RESET;
      limit_args     = lprd_pkg::MAX_ARGUMENT_COUNT_RESET;
      parse_phase    = lprd_pkg::PH_LENGTH;
      field_bytes    = '0;
      field_word     = '0;
      body_left      = '0;
      args_left      = '0;
      arg_index      = '0;
      arg_bytes_left = '0;
      msg_arg_count  = '0;
   endfunction

   // after the count word or an argument: next argument, message end or an error
   function automatic logic [lprd_pkg::CODE_WIDTH-1:0] close_argument(output logic msg_ok);
      msg_ok = 1'b0;
      if (args_left == '0) begin
         if (body_left == '0) begin
            msg_ok      = 1'b1;
            parse_phase = lprd_pkg::PH_LENGTH;
            return lprd_pkg::ERR_NONE;
         end
         return lprd_pkg::ERR_TRAILING;
      end
      if (body_left < lprd_pkg::HEADER_BYTES)
         return lprd_pkg::ERR_HEADER_OVERRUN;
      parse_phase = lprd_pkg::PH_ARGLEN;
      return lprd_pkg::ERR_NONE;
   endfunction

   function automatic lprd_pkg::rsp_type predict_tag(input logic [lprd_pkg::BYTE_WIDTH-1:0] b);
      lprd_pkg::rsp_type               r;
      logic                            word_done;
      logic                            msg_ok;
      logic [lprd_pkg::CODE_WIDTH-1:0] code;
      r              = '0;
      r.payload_byte = b;
      word_done      = 1'b0;
      msg_ok         = 1'b0;
      code           = lprd_pkg::ERR_NONE;
      if (parse_phase == lprd_pkg::PH_ERROR) begin
         r.byte_kind = lprd_pkg::KIND_DISCARDED;
         return r;
      end
      case (parse_phase)
         lprd_pkg::PH_LENGTH: r.byte_kind = lprd_pkg::KIND_MESSAGE_LENGTH;
         lprd_pkg::PH_COUNT:  r.byte_kind = lprd_pkg::KIND_ARGUMENT_COUNT;
         lprd_pkg::PH_ARGLEN: r.byte_kind = lprd_pkg::KIND_ARGUMENT_LENGTH;
         default:             r.byte_kind = lprd_pkg::KIND_ARGUMENT_DATA;
      endcase
      // length and count words assemble little-endian
      if (parse_phase != lprd_pkg::PH_PAYLOAD) begin
         field_word = field_word | ({24'd0, b} << (8 * field_bytes));
         if (field_bytes == 2'd3)
            word_done = 1'b1;
         field_bytes = field_bytes + 2'd1;
      end
      if (parse_phase != lprd_pkg::PH_LENGTH)
         body_left = body_left - 16'd1;
      case (parse_phase)
         lprd_pkg::PH_LENGTH: begin
            if (word_done) begin
               if (field_word > {16'd0, limit_length})
                  code = lprd_pkg::ERR_TOO_LONG;
               else if (field_word < lprd_pkg::MIN_BODY_LENGTH)
                  code = lprd_pkg::ERR_BODY_SHORT;
               else begin
                  body_left   = field_word[lprd_pkg::INDEX_WIDTH-1:0];
                  parse_phase = lprd_pkg::PH_COUNT;
               end
            end
         end
         lprd_pkg::PH_COUNT: begin
            if (word_done) begin
               if (field_word > {16'd0, limit_args})
                  code = lprd_pkg::ERR_TOO_MANY_ARGS;
               else begin
                  args_left     = field_word[lprd_pkg::INDEX_WIDTH-1:0];
                  msg_arg_count = field_word[lprd_pkg::INDEX_WIDTH-1:0];
                  arg_index     = '0;
                  code          = close_argument(msg_ok);
               end
            end
         end
         lprd_pkg::PH_ARGLEN: begin
            r.argument_index = arg_index;
            if (word_done) begin
               if (field_word > {16'd0, body_left})
                  code = lprd_pkg::ERR_PAYLOAD_OVERRUN;
               else if (field_word == '0) begin
                  // zero-length argument ends on its header
                  r.argument_end = 1'b1;
                  args_left      = args_left - 16'd1;
                  arg_index      = arg_index + 16'd1;
                  code           = close_argument(msg_ok);
               end else begin
                  arg_bytes_left = field_word[lprd_pkg::INDEX_WIDTH-1:0];
                  parse_phase    = lprd_pkg::PH_PAYLOAD;
               end
            end
         end
         default: begin
            r.argument_index = arg_index;
            arg_bytes_left   = arg_bytes_left - 16'd1;
            if (arg_bytes_left == '0) begin
               r.argument_end = 1'b1;
               args_left      = args_left - 16'd1;
               arg_index      = arg_index + 16'd1;
               code           = close_argument(msg_ok);
            end
         end
      endcase
      if (word_done)
         field_word = '0;
      r.argument_total = msg_arg_count;
      if (code != lprd_pkg::ERR_NONE) begin
         parse_phase    = lprd_pkg::PH_ERROR;
         r.argument_end = 1'b0;
         msg_ok         = 1'b0;
         r.error_flag   = 1'b1;
         r.error_code   = code;
      end
      if (msg_ok) begin
         msg_arg_count = '0;
         arg_index     = '0;
         args_left     = '0;
         body_left     = '0;
      end
      r.message_end = msg_ok;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] expected,
                                         input logic [15:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endfunction

   // result side: random stall per item, with stall-free stretches
   always @(posedge clock) begin : result_check
      lprd_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (tagged_q.size() == 0) begin
               $error("unexpected item: kind %0d, byte %0d", rsp_if.byte_kind,
                      rsp_if.payload_byte);
               error_count++;
            end else begin
               want = tagged_q.pop_front();
               compare_field("byte_kind", 16'(want.byte_kind), 16'(rsp_if.byte_kind));
               compare_field("payload_byte", 16'(want.payload_byte),
                             16'(rsp_if.payload_byte));
               compare_field("argument_index", want.argument_index, rsp_if.argument_index);
               compare_field("argument_end", 16'(want.argument_end),
                             16'(rsp_if.argument_end));
               compare_field("message_end", 16'(want.message_end), 16'(rsp_if.message_end));
               compare_field("argument_total", want.argument_total, rsp_if.argument_total);
               compare_field("error_flag", 16'(want.error_flag), 16'(rsp_if.error_flag));
               compare_field("error_code", 16'(want.error_code), 16'(rsp_if.error_code));
            end
            if ($urandom_range(0, 49) == 0)
               rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 13);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_if.ready <= (rsp_stall == 0);
      end
   end

   // one request byte: random gap, then hold valid until the handshake
   task automatic send_byte(input logic [lprd_pkg::BYTE_WIDTH-1:0] b);
      int                gap;
      lprd_pkg::rsp_type tag;
      if ($urandom_range(0, 39) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      tag      = predict_tag(b);
      tagged_q = {tagged_q, tag};
   endtask

   task automatic send_stream();
      foreach (stream_q[i])
         send_byte(stream_q[i]);
      stream_q.delete();
   endtask

   // every byte gives one item, so the block is idle once the last item is back
   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      while (tagged_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limits(input logic [lprd_pkg::CSR_DATA_WIDTH-1:0] length_limit,
                               input logic [lprd_pkg::CSR_DATA_WIDTH-1:0] count_limit);
      csr_write_enable <= 1'b1;
      csr_index        <= lprd_pkg::CSR_MAX_MESSAGE_LENGTH;
      csr_write_data   <= length_limit;
      @(posedge clock);
      csr_index        <= lprd_pkg::CSR_MAX_ARGUMENT_COUNT;
      csr_write_data   <= count_limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_length = length_limit;
      limit_args   = count_limit;
   endtask

   function automatic void add_word(input logic [lprd_pkg::WORD_WIDTH-1:0] w);
      for (int i = 0; i < 4; i++)
         stream_q = {stream_q, w[8*i +: 8]};
   endfunction

   function automatic void add_payload(input int n);
      for (int i = 0; i < n; i++)
         stream_q = {stream_q, 8'($urandom_range(0, 255))};
   endfunction

   // well-formed message within the current limits, mostly short arguments
   function automatic void add_random_message();
      int want;
      int len;
      int body;
      int lens [$];
      want = $urandom_range(0, (limit_args < 5) ? int'(limit_args) : 5);
      body = 4;
      for (int i = 0; i < want; i++) begin
         len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
         if (body + 4 + len > int'(limit_length))
            break;
         lens = {lens, len};
         body += 4 + len;
      end
      add_word(body);
      add_word(lens.size());
      foreach (lens[i]) begin
         add_word(lens[i]);
         add_payload(lens[i]);
      end
   endfunction

   // reset limits: empty message, then a zero-length and a two-byte argument
   task automatic test_directed_frames();
      add_word(4);
      add_word(0);
      add_word(14);
      add_word(2);
      add_word(0);
      add_word(2);
      stream_q = {stream_q, 8'h00};
      stream_q = {stream_q, 8'hFF};
      send_stream();
      drain_pipeline();
   endtask

   task automatic test_limit_extremes();
      // smallest limits: only an empty message fits
      write_limits(16'd4, 16'd0);
      add_word(4);
      add_word(0);
      send_stream();
      drain_pipeline();
      // message length and argument count exactly at their limits
      write_limits(16'd20, 16'd2);
      add_word(20);
      add_word(2);
      add_word(4);
      add_payload(4);
      add_word(4);
      add_payload(4);
      send_stream();
      drain_pipeline();
      write_limits(16'hFFFF, 16'hFFFF);
      repeat (2) add_random_message();
      send_stream();
      drain_pipeline();
   endtask

   task automatic test_random_traffic();
      int                                  sent;
      int                                  pick;
      logic [lprd_pkg::CSR_DATA_WIDTH-1:0] new_length;
      logic [lprd_pkg::CSR_DATA_WIDTH-1:0] new_count;
      sent = 0;
      while (sent < 650) begin
         pick = $urandom_range(0, 5);
         new_length = (pick == 0) ? 16'd4 : (pick == 1) ? 16'hFFFF :
                      16'($urandom_range(8, 700));
         pick = $urandom_range(0, 5);
         new_count = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                     16'($urandom_range(1, 12));
         write_limits(new_length, new_count);
         repeat ($urandom_range(4, 10)) add_random_message();
         sent += stream_q.size();
         send_stream();
         drain_pipeline();
      end
   endtask

   // one framing error per run, since only reset leaves the discard state
   task automatic test_framing_error();
      logic [lprd_pkg::CODE_WIDTH-1:0] which;
      int                              k;
      write_limits(16'($urandom_range(40, 65535)), 16'($urandom_range(2, 65535)));
      if ($urandom_range(0, 1) == 1)
         add_random_message();
      which = lprd_pkg::CODE_WIDTH'($urandom_range(1, 6));
      k = $urandom_range(1, 3);
      case (which)
         lprd_pkg::ERR_TOO_LONG: begin
            if ($urandom_range(0, 1) == 1)
               add_word(32'(limit_length) + 32'd1);
            else
               add_word($urandom | 32'h0001_0000);
         end
         lprd_pkg::ERR_BODY_SHORT: add_word($urandom_range(0, 3));
         lprd_pkg::ERR_TOO_MANY_ARGS: begin
            add_word($urandom_range(4, 40));
            if ($urandom_range(0, 1) == 1)
               add_word(32'(limit_args) + 32'd1);
            else
               add_word($urandom | 32'h0001_0000);
         end
         lprd_pkg::ERR_HEADER_OVERRUN: begin
            // too few body bytes for the next header, after the count or an argument
            if ($urandom_range(0, 1) == 1) begin
               add_word(4 + k);
               add_word(1);
            end else begin
               add_word(8 + k);
               add_word(2);
               add_word(0);
            end
         end
         lprd_pkg::ERR_PAYLOAD_OVERRUN: begin
            k = $urandom_range(0, 20);
            add_word(8 + k);
            add_word(1);
            add_word(k + 1 + $urandom_range(0, 1000));
         end
         default: begin
            // body bytes left over after the count or the last argument
            if ($urandom_range(0, 1) == 1) begin
               add_word(4 + k);
               add_word(0);
            end else begin
               add_word(10 + k);
               add_word(1);
               add_word(2);
               add_payload(2);
            end
         end
      endcase
      add_payload($urandom_range(10, 40));
      send_stream();
      drain_pipeline();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      rsp_if.ready     = 1'b0;
      error_count      = 0;
      req_calm         = 1'b0;
      rsp_calm         = 1'b0;
      rsp_stall        = 0;
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_limit_extremes();
      test_random_traffic();
      test_framing_error();
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
